@@ src/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the clock after the antecedent.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ src/pip_pkg.sv @@
// Package for the point-in-polygon test block: command codes, micro-program
// layout and the control ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

	// fixed field widths
	localparam int VIDX_BITS         = 6;
	localparam int CNT_CFG_BITS      = 7;
	localparam int MIN_POLY_VERTICES = 3;

	// command codes of an input beat
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// micro-program counter and step addresses
	typedef logic [2:0] upc_t;
	localparam upc_t UPC_IDLE   = 3'd0;
	localparam upc_t UPC_START  = 3'd1;
	localparam upc_t UPC_WALK   = 3'd2;
	localparam upc_t UPC_DRAIN  = 3'd3;
	localparam upc_t UPC_RESULT = 3'd4;

	// jump conditions
	typedef enum logic [2:0] {
		COND_QUERY,
		COND_FEW,
		COND_LAST,
		COND_DRAINED,
		COND_OUT_FREE
	} cond_t;

	// one control word
	typedef struct packed {
		logic  in_rdy;
		logic  clr;
		logic  rd_last;
		logic  rd_cnt;
		logic  out_load;
		cond_t cond;
		upc_t  tgt_t;
		upc_t  tgt_f;
	} ucw_t;

	// control from the sequencer to the edge pipeline
	typedef struct packed {
		logic clr;
		logic rd;
		logic walk;
	} pip_ctl_t;

	// control program
	function automatic ucw_t ucode(upc_t pc);
		ucw_t w;
		w = '0;
		case (pc)
			UPC_IDLE: begin
				w.in_rdy = 1'b1;
				w.cond   = COND_QUERY;
				w.tgt_t  = UPC_START;
				w.tgt_f  = UPC_IDLE;
			end
			UPC_START: begin
				w.clr     = 1'b1;
				w.rd_last = 1'b1;
				w.cond    = COND_FEW;
				w.tgt_t   = UPC_RESULT;
				w.tgt_f   = UPC_WALK;
			end
			UPC_WALK: begin
				w.rd_cnt = 1'b1;
				w.cond   = COND_LAST;
				w.tgt_t  = UPC_DRAIN;
				w.tgt_f  = UPC_WALK;
			end
			UPC_DRAIN: begin
				w.cond  = COND_DRAINED;
				w.tgt_t = UPC_RESULT;
				w.tgt_f = UPC_DRAIN;
			end
			UPC_RESULT: begin
				w.out_load = 1'b1;
				w.cond     = COND_OUT_FREE;
				w.tgt_t    = UPC_IDLE;
				w.tgt_f    = UPC_RESULT;
			end
			default: begin
				w.cond  = COND_QUERY;
				w.tgt_t = UPC_IDLE;
				w.tgt_f = UPC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ src/pip_if.sv @@
// Valid/ready channel interfaces for the point-in-polygon test block.
// Depends on pip_pkg for the vertex index width.
`timescale 1ns / 1ps
`default_nettype none

interface pip_in_if import pip_pkg::*; #(
	parameter int COORD_BITS = 28
) ();
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic        [VIDX_BITS-1:0]  vertex_index;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;

	modport source (output valid, cmd, vertex_index, coord_x, coord_y, input ready);
	modport sink   (input valid, cmd, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if ();
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink   (input valid, inside_res, output ready);
endinterface

`default_nettype wire

@@ src/pip_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/pip_edge.sv @@
// Edge test pipeline: keeps the previous vertex, forms the differences,
// multiplies in split partial products and toggles the even-odd flag.
// Depends on pip_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module pip_edge import pip_pkg::*; #(
	parameter int COORD_BITS = 28
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pip_ctl_t                     ctl,
	input  wire logic signed [COORD_BITS-1:0] pt_x,
	input  wire logic signed [COORD_BITS-1:0] pt_y,
	input  wire logic signed [COORD_BITS-1:0] vx,
	input  wire logic signed [COORD_BITS-1:0] vy,
	output logic                              busy,
	output logic                              in_poly
);

	localparam int D  = COORD_BITS + 1;
	localparam int LW = D / 2;
	localparam int HW = D - LW;
	localparam int MW = LW + 1 + HW;
	localparam int PW = 2 * D;

	logic                         rd_q;
	logic                         walk_q;
	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;

	logic signed [D-1:0] da;
	logic signed [D-1:0] dy;
	logic signed [D-1:0] dxe;
	logic signed [D-1:0] dq;
	logic                strad;

	logic                v_s1;
	logic                pos_s1;
	logic signed [D-1:0] opa_s1 [2];
	logic signed [D-1:0] opb_s1 [2];

	logic                 v_s2;
	logic                 pos_s2;
	logic [2*LW-1:0]      pll_s2 [2];
	logic signed [MW-1:0] plh_s2 [2];
	logic signed [MW-1:0] phl_s2 [2];
	logic signed [2*HW-1:0] phh_s2 [2];

	logic                 v_s3;
	logic                 pos_s3;
	logic signed [PW-1:0] prod   [2];
	logic signed [PW-1:0] prod_s3 [2];

	logic left;
	logic in_poly_q;

	// track reads issued last cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= 1'b0;
			walk_q <= 1'b0;
		end else begin
			rd_q   <= ctl.rd;
			walk_q <= ctl.walk;
		end
	end

	// hold the previous vertex, it closes the edge with the current one
	always_ff @(posedge clk) begin
		if (rd_q) begin
			prev_x_q <= vx;
			prev_y_q <= vy;
		end
	end

	// differences and straddle test
	always_comb begin
		da    = {pt_x[COORD_BITS-1], pt_x} - {vx[COORD_BITS-1], vx};
		dy    = {prev_y_q[COORD_BITS-1], prev_y_q} - {vy[COORD_BITS-1], vy};
		dxe   = {prev_x_q[COORD_BITS-1], prev_x_q} - {vx[COORD_BITS-1], vx};
		dq    = {pt_y[COORD_BITS-1], pt_y} - {vy[COORD_BITS-1], vy};
		strad = (vy > pt_y) != (prev_y_q > pt_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= walk_q & strad;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: operands of both products
	always_ff @(posedge clk) begin
		opa_s1[0] <= da;
		opb_s1[0] <= dy;
		opa_s1[1] <= dxe;
		opb_s1[1] <= dq;
		pos_s1    <= ~dy[D-1];
	end

	// stage 2: four partial products per lane
	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			pll_s2[k] <= opa_s1[k][LW-1:0] * opb_s1[k][LW-1:0];
			plh_s2[k] <= $signed({1'b0, opa_s1[k][LW-1:0]}) * $signed(opb_s1[k][D-1:LW]);
			phl_s2[k] <= $signed(opa_s1[k][D-1:LW]) * $signed({1'b0, opb_s1[k][LW-1:0]});
			phh_s2[k] <= $signed(opa_s1[k][D-1:LW]) * $signed(opb_s1[k][D-1:LW]);
		end
		pos_s2 <= pos_s1;
	end

	// combine partial products into the full-width products
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			prod[k] = ({{(PW-2*HW){phh_s2[k][2*HW-1]}}, phh_s2[k]} <<< (2*LW))
				+ ({{(PW-MW){plh_s2[k][MW-1]}}, plh_s2[k]} <<< LW)
				+ ({{(PW-MW){phl_s2[k][MW-1]}}, phl_s2[k]} <<< LW)
				+ {{(PW-2*LW){1'b0}}, pll_s2[k]};
		end
	end

	// stage 3: products
	always_ff @(posedge clk) begin
		prod_s3[0] <= prod[0];
		prod_s3[1] <= prod[1];
		pos_s3     <= pos_s2;
	end

	// compare, sense flips with the sign of dy
	assign left = pos_s3 ? (prod_s3[0] < prod_s3[1]) : (prod_s3[1] < prod_s3[0]);

	// even-odd flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_poly_q <= 1'b0;
		end else if (ctl.clr) begin
			in_poly_q <= 1'b0;
		end else if (v_s3 && left) begin
			in_poly_q <= ~in_poly_q;
		end
	end

	assign busy    = rd_q | walk_q | v_s1 | v_s2 | v_s3;
	assign in_poly = in_poly_q;

endmodule

`default_nettype wire

@@ src/point_in_polygon_test_core.sv @@
// Top level of the point-in-polygon test block: control sequencer, vertex RAM
// and edge pipeline. Depends on pip_pkg, pip_if, pip_ram and pip_edge.
`timescale 1ns / 1ps
`default_nettype none

// Even-odd ray-casting test of a point against a polygon held in an on-chip
// vertex table. A write beat (cmd 0) stores one vertex; a query beat (cmd 1)
// returns one inside_res beat. A query walks the n polygon edges one per cycle
// through a single RAM read port, where n is vertex_count saturated to
// MAX_VERTICES: one start step, n walk steps, drain steps until the edge
// pipeline is empty and the result step. With fewer than three vertices the
// walk and drain are skipped and the result answers outside. A result step
// also waits while the output register still holds an untaken beat. The input
// side reopens as the result is loaded into the output register, so the next
// beat is taken while the result waits. The user must write vertex_count
// through cfg_we only while no query is in progress; the block itself does
// not enforce this. Slots never written must not be part of a queried
// polygon.
module point_in_polygon_test_core import pip_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 28
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CNT_CFG_BITS-1:0] vertex_count,
	pip_in_if.sink                       item,
	pip_out_if.source                    result
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	upc_t    pc_q;
	upc_t    pc_d;
	ucw_t    uw;
	logic    cond_v;

	logic [NW-1:0] n_q;
	logic [NW-1:0] n_m1;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] raddr;

	logic in_beat;
	logic query;
	logic wr_en;

	logic signed [COORD_BITS-1:0] pt_x_q;
	logic signed [COORD_BITS-1:0] pt_y_q;
	logic [2*COORD_BITS-1:0]      rdata;

	pip_ctl_t ctl;
	logic     busy;
	logic     in_poly;

	logic out_valid_q;
	logic out_res_q;

	// decode the current control word
	assign uw      = ucode(pc_q);
	assign n_m1    = n_q - NW'(1);
	assign in_beat = item.valid & item.ready;
	assign query   = in_beat & (item.cmd == CMD_QUERY);
	assign wr_en   = in_beat & (item.cmd == CMD_WRITE)
		& (32'(item.vertex_index) < MAX_VERTICES);

	// jump condition
	always_comb begin
		case (uw.cond)
			COND_QUERY:    cond_v = query;
			COND_FEW:      cond_v = n_q < NW'(MIN_POLY_VERTICES);
			COND_LAST:     cond_v = NW'(cnt_q) == n_m1;
			COND_DRAINED:  cond_v = ~busy;
			COND_OUT_FREE: cond_v = ~out_valid_q | result.ready;
			default:       cond_v = 1'b0;
		endcase
	end

	assign pc_d = cond_v ? uw.tgt_t : uw.tgt_f;

	// advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// vertex counter for the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (uw.clr) begin
			cnt_q <= '0;
		end else if (uw.rd_cnt) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// configuration register, saturated at the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cfg_we) begin
			if (32'(vertex_count) > MAX_VERTICES) begin
				n_q <= NW'(MAX_VERTICES);
			end else begin
				n_q <= NW'(vertex_count);
			end
		end
	end

	// hold the query point
	always_ff @(posedge clk) begin
		if (query) begin
			pt_x_q <= item.coord_x;
			pt_y_q <= item.coord_y;
		end
	end

	assign item.ready = uw.in_rdy;

	// vertex table, last vertex read first to close the polygon
	assign raddr = uw.rd_last ? n_m1[AW-1:0] : cnt_q;

	pip_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(item.vertex_index)),
		.wdata ({item.coord_y, item.coord_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ctl.clr  = uw.clr;
	assign ctl.rd   = uw.rd_last | uw.rd_cnt;
	assign ctl.walk = uw.rd_cnt;

	pip_edge #(
		.COORD_BITS (COORD_BITS)
	) u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.pt_x    (pt_x_q),
		.pt_y    (pt_y_q),
		.vx      (rdata[COORD_BITS-1:0]),
		.vy      (rdata[2*COORD_BITS-1:COORD_BITS]),
		.busy    (busy),
		.in_poly (in_poly)
	);

	// output register: load on the result step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.out_load && cond_v) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.out_load && cond_v) begin
			out_res_q <= in_poly;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.inside_res = out_res_q;

endmodule

`default_nettype wire

@@ src/pip_checker.sv @@
// Port-level checker for point_in_polygon_test_core, bound to the top level.
// Depends on pip_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pip_checker import pip_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic in_cmd,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_res
);

	// a vertex write never produces a result beat
	`PIP_ASSERT_NEXT(a_write_no_result, in_valid && in_ready && in_cmd == CMD_WRITE && !out_valid, !out_valid, "vertex write produced a result")

	// a query holds off the input side while it runs
	`PIP_ASSERT_NEXT(a_query_blocks_input, in_valid && in_ready && in_cmd == CMD_QUERY, !in_ready, "input taken during a query")

	// a result never appears in the cycle right after its query
	`PIP_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && in_cmd == CMD_QUERY, !$rose(out_valid), "result appeared too early")

	// a stalled result beat holds
	`PIP_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_res), "stalled result beat changed")

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_cmd    (item.cmd),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_res   (result.inside_res)
);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for point_in_polygon_test_core: vertex loads, even-odd
// queries and vertex_count changes, checked against an in-bench polygon predictor.
// Depends on pip_pkg and the pip_in_if / pip_out_if channel interfaces.
`timescale 1ns / 1ps

module tb;
	import pip_pkg::*;

	localparam int CW            = 28;
	localparam int TABLE_DEPTH   = 64;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int DRAIN_CYCLES  = 80;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

	typedef enum int {SPAN_TIGHT, SPAN_MID, SPAN_FULL} span_t;

	// Polygon predictor: shadow vertex table, vertex count and queued answers
	class polygon_oracle;
		logic signed [CW-1:0] vx [TABLE_DEPTH];
		logic signed [CW-1:0] vy [TABLE_DEPTH];
		logic [CNT_CFG_BITS-1:0] count;
		bit expected_inside [$];
		int errors;
		int checked;
		int hits;

		function new();
			count   = '0;
			errors  = 0;
			checked = 0;
			hits    = 0;
		endfunction

		// Even-odd crossing count along a ray towards +x, exact cross-multiplied test
		function bit point_in_polygon(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
			int n, i, j;
			longint x, y, xi, yi, xj, yj, dy, lhs, rhs;
			bit odd, left;
			n = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
			odd = 1'b0;
			if (n < MIN_POLY_VERTICES)
				return 1'b0;
			x = px;
			y = py;
			for (i = 0; i < n; i++) begin
				j  = (i == 0) ? n - 1 : i - 1;
				xi = vx[i];
				yi = vy[i];
				xj = vx[j];
				yj = vy[j];
				if ((yi > y) != (yj > y)) begin
					dy   = yj - yi;
					lhs  = (x - xi) * dy;
					rhs  = (xj - xi) * (y - yi);
					left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
					if (left)
						odd = !odd;
				end
			end
			return odd;
		endfunction

		// Record one accepted input beat
		function void note_item(logic c, logic [VIDX_BITS-1:0] idx,
				logic signed [CW-1:0] x, logic signed [CW-1:0] y);
			if (c == CMD_WRITE) begin
				vx[idx] = x;
				vy[idx] = y;
			end else begin
				expected_inside.push_back(point_in_polygon(x, y));
			end
		endfunction

		// Compare one accepted result beat with the oldest answer
		function void check_result(logic got);
			bit want;
			if (expected_inside.size() == 0) begin
				$error("inside_res beat with no query outstanding: got %0b", got);
				errors++;
			end else begin
				want = expected_inside.pop_front();
				checked++;
				if (want)
					hits++;
				if (got !== want) begin
					$error("inside_res mismatch: expected %0b, actual %0b", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CNT_CFG_BITS-1:0] cfg_count;
	bit burst;
	int random_items;
	int beats_sent;
	int settings_done;
	polygon_oracle oracle;

	pip_in_if #(.COORD_BITS(CW)) item_ch ();
	pip_out_if result_ch ();

	point_in_polygon_test_core #(
		.MAX_VERTICES(TABLE_DEPTH),
		.COORD_BITS  (CW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.vertex_count(cfg_count),
		.item        (item_ch.sink),
		.result      (result_ch.source)
	);

	always #1 clk = ~clk;

	// Hard stop if the run hangs
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("point_in_polygon_test_core verification failed");
		$finish;
	end

	// Result side: random stall before each beat, sample at the rising edge
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			oracle.check_result(result_ch.inside_res);
		end
	end

	// Offer one beat after a random gap and hold it until taken
	task automatic send_beat(logic c, logic [VIDX_BITS-1:0] idx,
			logic signed [CW-1:0] x, logic signed [CW-1:0] y);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid        <= 1'b1;
		item_ch.cmd          <= c;
		item_ch.vertex_index <= idx;
		item_ch.coord_x      <= x;
		item_ch.coord_y      <= y;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		oracle.note_item(c, idx, x, y);
		beats_sent++;
	endtask

	// Drop valid, wait for every answer, then let the block drain
	task automatic quiesce();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (oracle.expected_inside.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write vertex_count while the block is idle
	task automatic program_count(logic [CNT_CFG_BITS-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_count <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		oracle.count = value;
		settings_done++;
	endtask

	function automatic logic signed [CW-1:0] draw_coord(span_t span);
		logic signed [CW-1:0] v;
		case (span)
			SPAN_TIGHT: v = CW'($urandom_range(0, 16)) - CW'(8);
			SPAN_MID:   v = CW'($urandom_range(0, 8191)) - CW'(4096);
			default: begin
				case ($urandom_range(0, 7))
					0:       v = COORD_MIN;
					1:       v = COORD_MAX;
					2:       v = '0;
					default: v = CW'($urandom());
				endcase
			end
		endcase
		return v;
	endfunction

	// Query point: random, on a vertex, near an edge middle, or level with a vertex
	task automatic pick_query_point(span_t span, int n,
			output logic signed [CW-1:0] qx, output logic signed [CW-1:0] qy);
		int a, b, kind;
		kind = (n < MIN_POLY_VERTICES) ? 0 : $urandom_range(0, 9);
		a = (n > 0) ? $urandom_range(0, n - 1) : 0;
		b = (a == 0) ? n - 1 : a - 1;
		qx = draw_coord(span);
		qy = draw_coord(span);
		case (kind)
			6, 7: begin
				qx = oracle.vx[a];
				qy = oracle.vy[a];
			end
			8: begin
				qx = CW'((longint'(oracle.vx[a]) + longint'(oracle.vx[b])) >>> 1);
				qy = CW'((longint'(oracle.vy[a]) + longint'(oracle.vy[b])) >>> 1);
			end
			9: qy = oracle.vy[a];
			default: ;
		endcase
	endtask

	// One setting: program the count, load the polygon, then mixed traffic
	task automatic run_phase(int idx);
		logic [CNT_CFG_BITS-1:0] cnt;
		logic signed [CW-1:0] qx, qy;
		span_t span;
		int n, len;
		case (idx)
			0: cnt = 7'd127;
			1: cnt = 7'd64;
			default: begin
				case ($urandom_range(0, 9))
					0:       cnt = CNT_CFG_BITS'($urandom_range(0, 2));
					1:       cnt = 7'd64;
					2:       cnt = CNT_CFG_BITS'($urandom_range(65, 127));
					3, 4, 5: cnt = CNT_CFG_BITS'($urandom_range(3, 8));
					default: cnt = CNT_CFG_BITS'($urandom_range(3, 64));
				endcase
			end
		endcase
		quiesce();
		program_count(cnt);
		span  = span_t'($urandom_range(0, 2));
		burst = ($urandom_range(0, 3) == 0);
		n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
		for (int i = 0; i < n; i++)
			send_beat(CMD_WRITE, VIDX_BITS'(i), draw_coord(span), draw_coord(span));
		len = $urandom_range(20, 60);
		repeat (len) begin
			if ($urandom_range(0, 4) == 0) begin
				send_beat(CMD_WRITE, VIDX_BITS'($urandom()), draw_coord(span),
					draw_coord(span));
			end else begin
				pick_query_point(span, n, qx, qy);
				send_beat(CMD_QUERY, VIDX_BITS'($urandom()), qx, qy);
			end
		end
		random_items += n + len;
	endtask

	initial begin
		int phase;
		oracle       = new();
		random_items = 0;
		beats_sent   = 0;
		settings_done = 0;
		burst        = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_count    = '0;
		item_ch.valid        = 1'b0;
		item_ch.cmd          = CMD_WRITE;
		item_ch.vertex_index = '0;
		item_ch.coord_x      = '0;
		item_ch.coord_y      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Count still zero after reset: always outside
		send_beat(CMD_QUERY, 6'd0, COORD_MAX, COORD_MIN);
		quiesce();
		program_count(7'd3);

		// Full-range triangle with a horizontal base
		send_beat(CMD_WRITE, 6'd0, COORD_MIN, COORD_MIN);
		send_beat(CMD_WRITE, 6'd1, COORD_MAX, COORD_MIN);
		send_beat(CMD_WRITE, 6'd2, '0, COORD_MAX);
		send_beat(CMD_WRITE, 6'd63, COORD_MAX, COORD_MAX);
		send_beat(CMD_QUERY, 6'd0, '0, '0);
		send_beat(CMD_QUERY, 6'd0, COORD_MIN, COORD_MIN);
		send_beat(CMD_QUERY, 6'd0, '0, COORD_MIN);
		send_beat(CMD_QUERY, 6'd0, '0, COORD_MAX);
		send_beat(CMD_QUERY, 6'd0, COORD_MAX, COORD_MAX);
		send_beat(CMD_QUERY, 6'd0, COORD_MIN, COORD_MAX);
		send_beat(CMD_QUERY, 6'd63, COORD_MAX, '0);
		send_beat(CMD_QUERY, 6'd0, -CW'(67108864), '0);
		send_beat(CMD_QUERY, 6'd0, -CW'(1), -CW'(1));

		// Same triangle wound the other way round
		send_beat(CMD_WRITE, 6'd0, '0, COORD_MAX);
		send_beat(CMD_WRITE, 6'd2, COORD_MIN, COORD_MIN);
		send_beat(CMD_QUERY, 6'd0, '0, '0);
		send_beat(CMD_QUERY, 6'd0, CW'(1), CW'(1));
		send_beat(CMD_QUERY, 6'd0, COORD_MAX, COORD_MIN);

		// One and two vertices: outside whatever the table holds
		quiesce();
		program_count(7'd1);
		send_beat(CMD_QUERY, 6'd0, '0, '0);
		quiesce();
		program_count(7'd2);
		send_beat(CMD_QUERY, 6'd0, '0, '0);

		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			run_phase(phase);
			phase++;
		end
		burst = 1'b0;
		quiesce();

		$display("Covered %0d beats and %0d vertex_count settings; %0d queries checked, %0d inside.",
			beats_sent, settings_done, oracle.checked, oracle.hits);
		if (oracle.errors == 0 && oracle.expected_inside.size() == 0)
			$display("point_in_polygon_test_core verification clean");
		else
			$display("point_in_polygon_test_core verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/pip_pkg.sv
src/pip_if.sv
src/pip_ram.sv
src/pip_edge.sv
src/point_in_polygon_test_core.sv
src/pip_checker.sv
test/tb.sv
